// ----- hw/rtl/pta_pkg.sv -----
// Shared constants, types and the arctangent table for the point-to-arc offset block.
package pta_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int CORDIC_STEPS    = 30;
  localparam int ROT_LAT         = CORDIC_STEPS + 1;
  localparam int ROT_W           = 33;
  localparam int ROT_ZW          = 34;
  localparam int CFG_INDEX_W     = 3;
  localparam int PART_W          = 2;
  localparam int MID_DEPTH       = 4;
  localparam int OUT_DEPTH       = 4;

  localparam logic [31:0] KINV_Q30   = 32'd652032874;
  localparam logic [31:0] HALF_TURN  = 32'h8000_0000;
  localparam logic [31:0] QTR_TURN   = 32'h4000_0000;
  localparam logic [31:0] ROUND_Q30  = 32'h2000_0000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_ARC_RADIUS  = 3'd2,
    REG_START_ANGLE = 3'd3,
    REG_END_ANGLE   = 3'd4
  } cfg_reg_t;

  typedef enum logic [PART_W-1:0] {
    PART_ARC   = 2'd0,
    PART_START = 2'd1,
    PART_END   = 2'd2
  } part_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [31:0] atan_turn(input int unsigned i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051D;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2E;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2F9;
      15: r = 32'h0000517C;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A2F;
      19: r = 32'h00000517;
      20: r = 32'h0000028B;
      21: r = 32'h00000145;
      22: r = 32'h000000A2;
      23: r = 32'h00000051;
      24: r = 32'h00000028;
      25: r = 32'h00000014;
      26: r = 32'h0000000A;
      27: r = 32'h00000005;
      28: r = 32'h00000002;
      29: r = 32'h00000001;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/point_to_arc_offset.sv -----
// Top level of the point-to-arc offset block: registers, queues, front and back ends.
// Throughput: one word per cycle unless stalled, in all three 30-step CORDIC pipelines too.
// Stalls: the front stops when the middle queue is full, the back when the output queue is.
// Reset: synchronous, clears config registers and valid flags to zero and empties both queues.
module point_to_arc_offset #(
  parameter int COORD_WIDTH = pta_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = pta_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [COORD_WIDTH-1:0]         point_x,
  input  logic signed [COORD_WIDTH-1:0]         point_y,
  input  logic                                  pop,
  output logic                                  empty,
  output logic signed [COORD_WIDTH-1:0]         offset_x,
  output logic signed [COORD_WIDTH-1:0]         offset_y,
  output logic [pta_pkg::PART_W-1:0]            nearest_part,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pta_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [((COORD_WIDTH > ANGLE_WIDTH) ? COORD_WIDTH : ANGLE_WIDTH)-1:0] cfg_data
);
  import pta_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int AW    = ANGLE_WIDTH;
  localparam int MID_W = 2 * CW + AW + 1;
  localparam int OUT_W = 2 * CW + PART_W;

  logic signed [CW-1:0] center_x, center_y;
  logic [CW-2:0]        arc_radius;
  logic [AW-1:0]        start_angle, end_angle;

  fifo_stat_t           mid_stat, out_stat;
  logic                 front_en, back_en;
  logic                 f_valid, f_int;
  logic signed [CW-1:0] f_px, f_py;
  logic [AW-1:0]        f_theta;
  logic [MID_W-1:0]     mid_rd;
  logic                 b_valid;
  logic signed [CW-1:0] b_ox, b_oy;
  logic [PART_W-1:0]    b_part;
  logic [OUT_W-1:0]     out_rd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= '0;
      center_y    <= '0;
      arc_radius  <= '0;
      start_angle <= '0;
      end_angle   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTER_X:    center_x    <= cfg_data[CW-1:0];
        REG_CENTER_Y:    center_y    <= cfg_data[CW-1:0];
        REG_ARC_RADIUS:  arc_radius  <= cfg_data[CW-2:0];
        REG_START_ANGLE: start_angle <= cfg_data[AW-1:0];
        REG_END_ANGLE:   end_angle   <= cfg_data[AW-1:0];
        default: ;
      endcase
    end
  end

  assign front_en = !mid_stat.full;
  assign full     = mid_stat.full;
  assign back_en  = !out_stat.full;

  pta_vec #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW)) u_front (
    .clk(clk), .rst(rst), .en(front_en), .in_valid(push),
    .point_x(point_x), .point_y(point_y),
    .center_x(center_x), .center_y(center_y),
    .start_angle(start_angle), .end_angle(end_angle),
    .out_valid(f_valid), .out_px(f_px), .out_py(f_py),
    .out_theta(f_theta), .out_interior(f_int)
  );

  pta_fifo #(.WIDTH(MID_W), .DEPTH(MID_DEPTH)) u_mid (
    .clk(clk), .rst(rst),
    .wr_en(front_en && f_valid), .wr_data({f_px, f_py, f_theta, f_int}),
    .rd_en(back_en && !mid_stat.empty), .rd_data(mid_rd), .stat(mid_stat)
  );

  pta_back #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW)) u_back (
    .clk(clk), .rst(rst), .en(back_en), .in_valid(!mid_stat.empty),
    .in_px(mid_rd[MID_W-1 -: CW]), .in_py(mid_rd[MID_W-CW-1 -: CW]),
    .in_theta(mid_rd[AW:1]), .in_interior(mid_rd[0]),
    .center_x(center_x), .center_y(center_y), .arc_radius(arc_radius),
    .start_angle(start_angle), .end_angle(end_angle),
    .out_valid(b_valid), .offset_x(b_ox), .offset_y(b_oy), .nearest_part(b_part)
  );

  pta_fifo #(.WIDTH(OUT_W), .DEPTH(OUT_DEPTH)) u_out (
    .clk(clk), .rst(rst),
    .wr_en(back_en && b_valid), .wr_data({b_ox, b_oy, b_part}),
    .rd_en(pop && !out_stat.empty), .rd_data(out_rd), .stat(out_stat)
  );

  assign empty        = out_stat.empty;
  assign offset_x     = out_rd[OUT_W-1 -: CW];
  assign offset_y     = out_rd[OUT_W-CW-1 -: CW];
  assign nearest_part = out_rd[PART_W-1:0];

endmodule

// ----- hw/rtl/pta_fifo.sv -----
// Small register queue with count-based full and empty.
module pta_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [WIDTH-1:0]    wr_data,
  input  logic                rd_en,
  output logic [WIDTH-1:0]    rd_data,
  output pta_pkg::fifo_stat_t stat
);
  import pta_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;

  assign rd_data    = mem[rd_ptr];
  assign stat.full  = (count == (AW+1)'(DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en && !rd_en |-> !stat.full) else $error("write into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !stat.empty) else $error("read from empty queue");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    wr_en && !rd_en |=> count == $past(count) + 1'b1) else $error("count lost a word");

endmodule

// ----- hw/rtl/pta_vec.sv -----
// Front end: offset from center, pipelined vectoring CORDIC angle, interior test.
module pta_vec #(
  parameter int COORD_WIDTH = pta_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = pta_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  input  logic [ANGLE_WIDTH-1:0]        start_angle,
  input  logic [ANGLE_WIDTH-1:0]        end_angle,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] out_px,
  output logic signed [COORD_WIDTH-1:0] out_py,
  output logic [ANGLE_WIDTH-1:0]        out_theta,
  output logic                          out_interior
);
  import pta_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int VW = COORD_WIDTH + 4;
  localparam int N  = CORDIC_STEPS;
  localparam logic [31:0] RND = 32'(1) << (31 - ANGLE_WIDTH);

  logic signed [CW:0]    dx, dy;
  logic signed [VW-1:0]  xs [0:N];
  logic signed [VW-1:0]  ys [0:N];
  logic [31:0]           acc [0:N];
  logic                  vld [0:N];
  logic                  zr [0:N];
  logic signed [CW-1:0]  px [0:N];
  logic signed [CW-1:0]  py [0:N];
  logic [31:0]           rnd;

  assign dx = (CW+1)'(point_x) - (CW+1)'(center_x);
  assign dy = (CW+1)'(point_y) - (CW+1)'(center_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dx[CW]) begin
        xs[0]  <= -VW'(dx);
        ys[0]  <= -VW'(dy);
        acc[0] <= HALF_TURN;
      end else begin
        xs[0]  <= VW'(dx);
        ys[0]  <= VW'(dy);
        acc[0] <= '0;
      end
      zr[0] <= (dx == '0) && (dy == '0);
      px[0] <= point_x;
      py[0] <= point_y;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!ys[i][VW-1]) begin
          xs[i+1]  <= xs[i] + (ys[i] >>> i);
          ys[i+1]  <= ys[i] - (xs[i] >>> i);
          acc[i+1] <= acc[i] + atan_turn(i);
        end else begin
          xs[i+1]  <= xs[i] - (ys[i] >>> i);
          ys[i+1]  <= ys[i] + (xs[i] >>> i);
          acc[i+1] <= acc[i] - atan_turn(i);
        end
        zr[i+1] <= zr[i];
        px[i+1] <= px[i];
        py[i+1] <= py[i];
      end
    end
  end

  assign rnd          = acc[N] + RND;
  assign out_valid    = vld[N];
  assign out_px       = px[N];
  assign out_py       = py[N];
  assign out_theta    = zr[N] ? '0 : rnd[31 -: ANGLE_WIDTH];
  assign out_interior = (start_angle < out_theta) && (out_theta < end_angle);

endmodule

// ----- hw/rtl/pta_rot.sv -----
// Pipelined rotating CORDIC: angle to cos and sin in Q2.30.
module pta_rot #(
  parameter int ANGLE_WIDTH = pta_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [ANGLE_WIDTH-1:0]             angle,
  output logic signed [pta_pkg::ROT_W-1:0]   cos_q30,
  output logic signed [pta_pkg::ROT_W-1:0]   sin_q30
);
  import pta_pkg::*;

  localparam int N = CORDIC_STEPS;

  logic [31:0]              a, a2;
  logic                     flip;
  logic signed [ROT_W-1:0]  xs [0:N];
  logic signed [ROT_W-1:0]  ys [0:N];
  logic signed [ROT_ZW-1:0] zs [0:N];
  logic                     fl [0:N];

  assign a    = {angle, (32-ANGLE_WIDTH)'(0)};
  assign flip = (a + QTR_TURN) >= HALF_TURN;
  assign a2   = flip ? a + HALF_TURN : a;

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= ROT_W'(KINV_Q30);
      ys[0] <= '0;
      zs[0] <= ROT_ZW'(signed'(a2));
      fl[0] <= flip;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zs[i][ROT_ZW-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ROT_ZW'(atan_turn(i));
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ROT_ZW'(atan_turn(i));
        end
        fl[i+1] <= fl[i];
      end
    end
  end

  assign cos_q30 = fl[N] ? -xs[N] : xs[N];
  assign sin_q30 = fl[N] ? -ys[N] : ys[N];

endmodule

// ----- hw/rtl/pta_back.sv -----
// Back end: arc points, radius scaling, endpoint distance compare, saturated offset.
module pta_back #(
  parameter int COORD_WIDTH = pta_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = pta_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic signed [COORD_WIDTH-1:0]  in_px,
  input  logic signed [COORD_WIDTH-1:0]  in_py,
  input  logic [ANGLE_WIDTH-1:0]         in_theta,
  input  logic                           in_interior,
  input  logic signed [COORD_WIDTH-1:0]  center_x,
  input  logic signed [COORD_WIDTH-1:0]  center_y,
  input  logic [COORD_WIDTH-2:0]         arc_radius,
  input  logic [ANGLE_WIDTH-1:0]         start_angle,
  input  logic [ANGLE_WIDTH-1:0]         end_angle,
  output logic                           out_valid,
  output logic signed [COORD_WIDTH-1:0]  offset_x,
  output logic signed [COORD_WIDTH-1:0]  offset_y,
  output logic [pta_pkg::PART_W-1:0]     nearest_part
);
  import pta_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int L   = ROT_LAT;
  localparam int PW  = CW - 1 + ROT_W;
  localparam int DW  = CW + 3;
  localparam int MW  = DW;
  localparam int LH  = (MW + 1) / 2;
  localparam int HH  = MW - LH;
  localparam int SQW = 2 * MW;
  localparam int SW  = SQW + 1;

  // lanes: 0 start/arc x, 1 start/arc y, 2 end x, 3 end y
  logic signed [ROT_W-1:0] cs [4];
  logic signed [ROT_W-1:0] cos_a, sin_a, cos_b, sin_b;

  logic                  sd_v [0:L-1];
  logic                  sd_i [0:L-1];
  logic signed [CW-1:0]  sd_px [0:L-1];
  logic signed [CW-1:0]  sd_py [0:L-1];

  logic                  v1, v2, v3, v4, v5;
  logic                  i1, i2, i3, i4, i5;
  logic signed [CW-1:0]  px1, py1, px2, py2;
  logic [PW-1:0]         prod1 [4];
  logic                  neg1 [4];
  logic signed [CW+1:0]  pt2 [4];
  logic signed [DW-1:0]  d3 [4];
  logic signed [DW-1:0]  d4 [4];
  logic signed [DW-1:0]  d5 [4];
  logic [2*HH-1:0]       hh4 [4];
  logic [HH+LH-1:0]      hl4 [4];
  logic [2*LH-1:0]       ll4 [4];
  logic [SW-1:0]         sa5, sb5;
  logic [SQW-1:0]        sq [4];
  logic                  take_end;
  logic signed [DW-1:0]  sel_x, sel_y;

  pta_rot #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_rot_a (
    .clk(clk), .en(en), .angle(in_interior ? in_theta : start_angle),
    .cos_q30(cos_a), .sin_q30(sin_a)
  );

  pta_rot #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_rot_b (
    .clk(clk), .en(en), .angle(end_angle),
    .cos_q30(cos_b), .sin_q30(sin_b)
  );

  assign cs[0] = cos_a;
  assign cs[1] = sin_a;
  assign cs[2] = cos_b;
  assign cs[3] = sin_b;

  function automatic logic signed [CW:0] scale(input logic [PW-1:0] p, input logic n);
    logic [PW-1:0]      t;
    logic signed [CW:0] m;
    t = (p + PW'(ROUND_Q30)) >> 30;
    m = signed'(t[CW:0]);
    return n ? -m : m;
  endfunction

  function automatic logic signed [CW-1:0] sat(input logic signed [DW-1:0] d);
    logic [DW-CW:0] top;
    top = d[DW-1:CW-1];
    if (top == '0 || top == '1) begin
      return d[CW-1:0];
    end
    return d[DW-1] ? {1'b1, (CW-1)'(0)} : {1'b0, {(CW-1){1'b1}}};
  endfunction

  // side data kept in step with the CORDIC pipelines
  always_ff @(posedge clk) begin
    if (rst) begin
      sd_v[0] <= 1'b0;
    end else if (en) begin
      sd_v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_i[0]  <= in_interior;
      sd_px[0] <= in_px;
      sd_py[0] <= in_py;
    end
  end

  for (genvar k = 1; k < L; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        sd_v[k] <= 1'b0;
      end else if (en) begin
        sd_v[k] <= sd_v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd_i[k]  <= sd_i[k-1];
        sd_px[k] <= sd_px[k-1];
        sd_py[k] <= sd_py[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= sd_v[L-1];
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i1  <= sd_i[L-1];
      i2  <= i1;
      i3  <= i2;
      i4  <= i3;
      i5  <= i4;
      px1 <= sd_px[L-1];
      py1 <= sd_py[L-1];
      px2 <= px1;
      py2 <= py1;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_lane
    logic [ROT_W-1:0]     mag_c;
    logic [MW-1:0]        mag_d;
    logic signed [CW-1:0] ctr;
    logic signed [CW-1:0] pnt;

    assign mag_c = cs[k][ROT_W-1] ? ROT_W'(-cs[k]) : ROT_W'(cs[k]);
    assign ctr   = (k % 2 == 0) ? center_x : center_y;
    assign pnt   = (k % 2 == 0) ? px2 : py2;
    assign mag_d = d3[k][DW-1] ? MW'(-d3[k]) : MW'(d3[k]);

    always_ff @(posedge clk) begin
      if (en) begin
        prod1[k] <= PW'(arc_radius) * PW'(mag_c);
        neg1[k]  <= cs[k][ROT_W-1];
        pt2[k]   <= (CW+2)'(ctr) + (CW+2)'(scale(prod1[k], neg1[k]));
        d3[k]    <= DW'(pnt) - DW'(pt2[k]);
        hh4[k]   <= (2*HH)'(mag_d[MW-1:LH]) * (2*HH)'(mag_d[MW-1:LH]);
        hl4[k]   <= (HH+LH)'(mag_d[MW-1:LH]) * (HH+LH)'(mag_d[LH-1:0]);
        ll4[k]   <= (2*LH)'(mag_d[LH-1:0]) * (2*LH)'(mag_d[LH-1:0]);
        d4[k]    <= d3[k];
        d5[k]    <= d4[k];
      end
    end

    assign sq[k] = (SQW'(hh4[k]) << (2*LH)) + (SQW'(hl4[k]) << (LH+1)) + SQW'(ll4[k]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa5 <= SW'(sq[0]) + SW'(sq[1]);
      sb5 <= SW'(sq[2]) + SW'(sq[3]);
    end
  end

  assign take_end  = !i5 && (sb5 < sa5);
  assign sel_x     = take_end ? d5[2] : d5[0];
  assign sel_y     = take_end ? d5[3] : d5[1];
  assign out_valid = v5;
  assign offset_x  = sat(sel_x);
  assign offset_y  = sat(sel_y);
  assign nearest_part = i5 ? PART_ARC : (take_end ? PART_END : PART_START);

endmodule
